### hw/rtl/nfa_pkg.sv
package nfa_pkg;

  // Default automaton size
  localparam int unsigned NumStatesDef  = 16;
  localparam int unsigned NumSymbolsDef = 16;

  // Fixed field widths
  localparam int unsigned FuncW    = 2;
  localparam int unsigned StateW   = 4;
  localparam int unsigned SymbolW  = 4;
  localparam int unsigned MaskW    = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Number of indexes the 4-bit fields can address
  localparam int unsigned FieldRange = 16;

  // Register reset values
  localparam logic [StateW-1:0] StartReset = 4'd0;
  localparam logic [MaskW-1:0]  FinalReset = 16'd0;
  localparam logic [StateW-1:0] SinkReset  = 4'd15;

  // Request function codes
  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_SYMBOL = 2'd1,
    FUNC_EMPTY  = 2'd2
  } func_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START = 2'd0,
    CFG_FINAL = 2'd1,
    CFG_SINK  = 2'd2
  } cfg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN,
    ST_COMMIT,
    ST_REPORT
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic add_rd;
    logic add_wr;
    logic scan_rd;
    logic commit;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_done;
    logic last;
    logic out_free;
  } sts_t;

  // Clip a size to what the 4-bit fields can reach
  function automatic int unsigned clip_range(int unsigned n);
    return (n < FieldRange) ? n : FieldRange;
  endfunction

endpackage

### hw/rtl/nfa_if.sv
// Request channel: one add-transition, symbol or empty-word request
interface nfa_req_if;
  logic                           valid;
  logic                           ready;
  logic [nfa_pkg::FuncW-1:0]      func;
  logic [nfa_pkg::StateW-1:0]     from_state;
  logic [nfa_pkg::SymbolW-1:0]    symbol;
  logic [nfa_pkg::StateW-1:0]     next_state;
  logic                           to_sink;
  logic                           last_symbol;

  modport source (
    output valid, func, from_state, symbol, next_state, to_sink, last_symbol,
    input  ready
  );

  modport sink (
    input  valid, func, from_state, symbol, next_state, to_sink, last_symbol,
    output ready
  );
endinterface

// Response channel: verdict at the end of a word
interface nfa_rsp_if;
  logic valid;
  logic ready;
  logic accepted;
  logic died;

  modport source (
    output valid, accepted, died,
    input  ready
  );

  modport sink (
    input  valid, accepted, died,
    output ready
  );
endinterface

### hw/rtl/nfa_ctrl.sv
module nfa_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic [nfa_pkg::FuncW-1:0] req_func_i,
  output logic                      req_ready_o,
  input  nfa_pkg::sts_t             sts_i,
  output nfa_pkg::cmd_t             cmd_o
);

  nfa_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      nfa_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          case (nfa_pkg::func_e'(req_func_i))
            nfa_pkg::FUNC_ADD:    state_d = nfa_pkg::ST_ADD_RD;
            nfa_pkg::FUNC_SYMBOL: state_d = nfa_pkg::ST_SCAN;
            nfa_pkg::FUNC_EMPTY:  state_d = nfa_pkg::ST_REPORT;
            default:              state_d = nfa_pkg::ST_IDLE;
          endcase
        end
      end
      nfa_pkg::ST_ADD_RD: begin
        cmd_o.add_rd = 1'b1;
        state_d      = nfa_pkg::ST_ADD_WR;
      end
      nfa_pkg::ST_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = nfa_pkg::ST_IDLE;
      end
      nfa_pkg::ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_done) begin
          state_d = nfa_pkg::ST_COMMIT;
        end
      end
      nfa_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.last ? nfa_pkg::ST_REPORT : nfa_pkg::ST_IDLE;
      end
      nfa_pkg::ST_REPORT: begin
        // Hold until the response slot frees up
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = nfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nfa_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/nfa_dpath.sv
module nfa_dpath #(
  parameter int unsigned NUM_STATES  = nfa_pkg::NumStatesDef,
  parameter int unsigned NUM_SYMBOLS = nfa_pkg::NumSymbolsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nfa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [nfa_pkg::FuncW-1:0]    func_i,
  input  logic [nfa_pkg::StateW-1:0]   from_state_i,
  input  logic [nfa_pkg::SymbolW-1:0]  symbol_i,
  input  logic [nfa_pkg::StateW-1:0]   next_state_i,
  input  logic                         to_sink_i,
  input  logic                         last_symbol_i,
  input  nfa_pkg::cmd_t                cmd_i,
  output nfa_pkg::sts_t                sts_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         accepted_o,
  output logic                         died_o
);

  // Only states and symbols the 4-bit fields reach get storage
  localparam int unsigned EffStates  = nfa_pkg::clip_range(NUM_STATES);
  localparam int unsigned EffSymbols = nfa_pkg::clip_range(NUM_SYMBOLS);
  localparam int unsigned Depth      = EffStates * EffSymbols;
  localparam int unsigned AddrW      = $clog2(Depth);
  localparam int unsigned IdxW       = $clog2(EffStates);

  typedef logic [EffStates-1:0] set_t;

  // Configuration registers
  logic [nfa_pkg::StateW-1:0] start_q, sink_q;
  logic [nfa_pkg::MaskW-1:0]  final_q;

  // Latched request
  logic [nfa_pkg::StateW-1:0]  from_q, next_q;
  logic [nfa_pkg::SymbolW-1:0] sym_q;
  logic                        to_sink_q, last_q, is_sym_q;

  // Word state and scan
  set_t            active_q, acc_q, contrib;
  logic            word_begun_q;
  logic [IdxW-1:0] idx_q, tag_idx_q;
  logic            tag_q;

  // Transition store
  set_t             store_q [Depth];
  logic [Depth-1:0] vld_q;
  set_t             rdata_q, rd_word, wdata, start_bit, target_bit;
  logic             vld_rd_q;
  logic [AddrW-1:0] raddr, add_addr, scan_addr;
  logic             wr_en, sym_ok, from_ok, scan_done;

  // Response register
  logic out_valid_q, accepted_q, died_q, out_free;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= nfa_pkg::StartReset;
      final_q <= nfa_pkg::FinalReset;
      sink_q  <= nfa_pkg::SinkReset;
    end else if (cfg_we_i) begin
      case (nfa_pkg::cfg_idx_e'(cfg_idx_i))
        nfa_pkg::CFG_START: start_q <= cfg_data_i[nfa_pkg::StateW-1:0];
        nfa_pkg::CFG_FINAL: final_q <= cfg_data_i[nfa_pkg::MaskW-1:0];
        nfa_pkg::CFG_SINK:  sink_q  <= cfg_data_i[nfa_pkg::StateW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      from_q    <= from_state_i;
      sym_q     <= symbol_i;
      next_q    <= next_state_i;
      to_sink_q <= to_sink_i;
      last_q    <= last_symbol_i;
      is_sym_q  <= (nfa_pkg::func_e'(func_i) == nfa_pkg::FUNC_SYMBOL);
    end
  end

  // Decode indexes; a shift past the set width drops the state
  assign sym_ok     = int'(sym_q) < EffSymbols;
  assign from_ok    = int'(from_q) < EffStates;
  assign start_bit  = set_t'(1) << start_q;
  assign target_bit = set_t'(1) << (to_sink_q ? sink_q : next_q);
  assign add_addr   = AddrW'(from_q) * AddrW'(EffSymbols) + AddrW'(sym_q);
  assign scan_addr  = AddrW'(idx_q) * AddrW'(EffSymbols) + AddrW'(sym_q);
  assign raddr      = cmd_i.add_rd ? add_addr : scan_addr;
  assign scan_done  = idx_q == IdxW'(EffStates - 1);

  // Entries never written read as empty sets
  assign rd_word = vld_rd_q ? rdata_q : '0;
  assign wdata   = rd_word | target_bit;
  assign wr_en   = cmd_i.add_wr && from_ok && sym_ok;
  assign contrib = (tag_q && sym_ok && active_q[tag_idx_q]) ? rd_word : '0;

  // Store array and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[add_addr] <= wdata;
    end
    rdata_q  <= store_q[raddr];
    vld_rd_q <= vld_q[raddr];
  end

  // Mark written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[add_addr] <= 1'b1;
    end
  end

  // Advance the scan index and the read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      tag_q     <= 1'b0;
      tag_idx_q <= '0;
    end else begin
      tag_q     <= cmd_i.scan_rd;
      tag_idx_q <= idx_q;
      if (cmd_i.latch) begin
        idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Gather the union of table entries of the active states
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_q | contrib;
    end
  end

  // Seed and commit the active set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      word_begun_q <= 1'b0;
    end else if (cmd_i.latch) begin
      if (nfa_pkg::func_e'(func_i) == nfa_pkg::FUNC_EMPTY) begin
        active_q     <= start_bit;
        word_begun_q <= 1'b0;
      end else if (nfa_pkg::func_e'(func_i) == nfa_pkg::FUNC_SYMBOL && !word_begun_q) begin
        active_q     <= start_bit;
        word_begun_q <= 1'b1;
      end
    end else if (cmd_i.commit) begin
      active_q     <= acc_q | contrib;
      word_begun_q <= !last_q;
    end
  end

  // Hold the response until taken
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      accepted_q <= |(active_q & final_q[EffStates-1:0]);
      died_q     <= is_sym_q && (active_q == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = accepted_q;
  assign died_o          = died_q;
  assign sts_o.scan_done = scan_done;
  assign sts_o.last      = last_q;
  assign sts_o.out_free  = out_free;

`ifndef SYNTHESIS
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> out_free)
    else $error("response loaded while slot busy");

  a_died_rejects : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && died_q) |-> !accepted_q)
    else $error("dead word reported as accepted");

  a_commit_after_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> ($past(cmd_i.scan_rd) && $past(scan_done)))
    else $error("commit without a finished scan");

  a_write_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(cmd_i.add_rd))
    else $error("store written without a preceding read");
`endif

endmodule

### hw/rtl/nfa_word_acceptor.sv
// NFA word acceptor. Add-transition requests OR a target state (next_state, or
// the configured sink_state when to_sink is set) into the next-state set held
// for a (from_state, symbol) pair; symbol requests move the active set to the
// union of those sets over all active states, starting a word from start_state
// alone; the last symbol of a word, or an empty-word request, returns one
// response with accepted (some active state is final) and died (the set went
// empty). An add is a read-modify-write of the store; a symbol scans the
// min(NUM_STATES,16) states through the single read port of the transition
// store, one state per cycle, then commits, and on the last symbol loads the
// response; an empty-word request only loads the response. A new
// request is taken while an earlier response still waits on the output. The
// store is cleared at reset through per-entry valid flags, with no clearing
// pass. Configuration writes are taken any cycle but belong in idle periods.
module nfa_word_acceptor #(
  parameter int unsigned NUM_STATES  = nfa_pkg::NumStatesDef,
  parameter int unsigned NUM_SYMBOLS = nfa_pkg::NumSymbolsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [nfa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nfa_pkg::CfgDataW-1:0] cfg_data_i,
  nfa_req_if.sink                      req_i,
  nfa_rsp_if.source                    rsp_o
);

  nfa_pkg::cmd_t cmd;
  nfa_pkg::sts_t sts;

  // Sequencer
  nfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store, active set and response register
  nfa_dpath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (req_i.func),
    .from_state_i  (req_i.from_state),
    .symbol_i      (req_i.symbol),
    .next_state_i  (req_i.next_state),
    .to_sink_i     (req_i.to_sink),
    .last_symbol_i (req_i.last_symbol),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .accepted_o    (rsp_o.accepted),
    .died_o        (rsp_o.died)
  );

endmodule

### test/tb_nfa_word_acceptor.sv
module tb_nfa_word_acceptor;
  timeunit 1ns;
  timeprecision 1ps;

  import nfa_pkg::*;

  localparam int unsigned NStates  = NumStatesDef;
  localparam int unsigned NSymbols = NumSymbolsDef;
  localparam int unsigned Depth    = NStates * NSymbols;

  // Function code the block must ignore
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  // Settle time after the last verdict: covers a trailing add or symbol
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ReportLimit  = 10;

  typedef struct {
    logic [FuncW-1:0]   func;
    logic [StateW-1:0]  from_state;
    logic [SymbolW-1:0] symbol;
    logic [StateW-1:0]  next_state;
    logic               to_sink;
    logic               last_symbol;
  } req_item_t;

  typedef struct packed {
    logic accepted;
    logic died;
  } verdict_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  nfa_req_if req_if ();
  nfa_rsp_if rsp_if ();

  nfa_word_acceptor u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Automaton mirror
  logic [NStates-1:0] trans_sets [Depth];
  logic [NStates-1:0] active_states;
  logic               in_word;
  logic [StateW-1:0]  start_reg;
  logic [MaskW-1:0]   final_reg;
  logic [StateW-1:0]  sink_reg;

  req_item_t pending_reqs [$];
  verdict_t  verdicts_due [$];
  req_item_t cur_req;
  logic      req_accepted;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          hold_cycles;
  int          errors;

  // Append a request to the driver queue
  function automatic void queue_req(req_item_t it);
    pending_reqs.insert(pending_reqs.size(), it);
  endfunction

  // Append a verdict to the list of those still due
  function automatic void queue_verdict(verdict_t v);
    verdicts_due.insert(verdicts_due.size(), v);
  endfunction

  function automatic logic [NStates-1:0] state_mask(logic [StateW-1:0] s);
    if (s >= NStates) return '0;
    return NStates'(1) << s;
  endfunction

  // Advance the mirror by one accepted request; queue the verdict it yields
  task automatic step_automaton(req_item_t it);
    logic [NStates-1:0] nxt;
    verdict_t           v;
    case (it.func)
      FUNC_ADD: begin
        if (it.from_state < NStates && it.symbol < NSymbols)
          trans_sets[{it.from_state, it.symbol}] |=
            state_mask(it.to_sink ? sink_reg : it.next_state);
      end
      FUNC_SYMBOL: begin
        if (!in_word) begin
          active_states = state_mask(start_reg);
          in_word = 1'b1;
        end
        nxt = '0;
        if (it.symbol < NSymbols) begin
          for (int s = 0; s < NStates; s++)
            if (active_states[s]) nxt |= trans_sets[{StateW'(s), it.symbol}];
        end
        active_states = nxt;
        if (it.last_symbol) begin
          in_word    = 1'b0;
          v.accepted = |(active_states & final_reg[NStates-1:0]);
          v.died     = (active_states == '0);
          queue_verdict(v);
        end
      end
      FUNC_EMPTY: begin
        in_word       = 1'b0;
        active_states = state_mask(start_reg);
        v.accepted    = |(active_states & final_reg[NStates-1:0]);
        v.died        = 1'b0;
        queue_verdict(v);
      end
      default: ;
    endcase
  endtask

  function automatic req_item_t mk_req(logic [FuncW-1:0] func, logic [StateW-1:0] from,
                                       logic [SymbolW-1:0] sym, logic [StateW-1:0] nxt,
                                       logic to_sink, logic last);
    req_item_t it;
    it.func        = func;
    it.from_state  = from;
    it.symbol      = sym;
    it.next_state  = nxt;
    it.to_sink     = to_sink;
    it.last_symbol = last;
    return it;
  endfunction

  function automatic req_item_t rand_req(logic [FuncW-1:0] func);
    return mk_req(func, StateW'($urandom_range(15)), SymbolW'($urandom_range(15)),
                  StateW'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
  endfunction

  // Symbol request with random don't-care fields
  function automatic req_item_t sym_req(logic [SymbolW-1:0] sym, logic last);
    req_item_t it;
    it             = rand_req(FUNC_SYMBOL);
    it.symbol      = sym;
    it.last_symbol = last;
    return it;
  endfunction

  task automatic report_error(string what, verdict_t exp, verdict_t got);
    errors++;
    if (errors <= ReportLimit)
      $display("%0t: %s: expected accepted=%0b died=%0b, got accepted=%0b died=%0b",
               $time, what, exp.accepted, exp.died, got.accepted, got.died);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Request driver: hold each request until accepted
  always @(posedge clk) begin
    req_accepted <= rst_n && req_if.valid && req_if.ready;
    if (rst_n && req_if.valid && req_if.ready) step_automaton(cur_req);
  end

  always @(negedge clk) begin
    if (rst_n && (!req_if.valid || req_accepted)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        req_if.func        <= cur_req.func;
        req_if.from_state  <= cur_req.from_state;
        req_if.symbol      <= cur_req.symbol;
        req_if.next_state  <= cur_req.next_state;
        req_if.to_sink     <= cur_req.to_sink;
        req_if.last_symbol <= cur_req.last_symbol;
        req_if.valid       <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response sink: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Verdict checker
  always @(posedge clk) begin
    verdict_t got;
    verdict_t exp;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.accepted = rsp_if.accepted;
      got.died     = rsp_if.died;
      if (verdicts_due.size() == 0) begin
        exp = '0;
        report_error("unexpected verdict", exp, got);
      end else begin
        exp = verdicts_due.pop_front();
        if (exp.accepted !== got.accepted || exp.died !== got.died)
          report_error("verdict mismatch", exp, got);
      end
    end
  end

  task automatic write_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    case (idx)
      CFG_START: start_reg = data[StateW-1:0];
      CFG_FINAL: final_reg = data[MaskW-1:0];
      CFG_SINK:  sink_reg  = data[StateW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Wait until every request is taken and every verdict is in, then settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || verdicts_due.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic push_directed();
    queue_req(mk_req(FUNC_ADD, 0, 0, 1, 0, 0));
    queue_req(mk_req(FUNC_ADD, 1, 1, 0, 1, 0));
    queue_req(mk_req(FUNC_ADD, 15, 15, 0, 0, 1));
    // Chain through the sink back to the start state
    queue_req(sym_req(0, 0));
    queue_req(sym_req(1, 0));
    queue_req(sym_req(15, 1));
    // Word dies and stays dead
    queue_req(sym_req(5, 0));
    queue_req(sym_req(0, 1));
    queue_req(mk_req(FUNC_EMPTY, 0, 0, 0, 0, 0));
    // Empty-word request cuts a word short
    queue_req(sym_req(0, 0));
    queue_req(mk_req(FUNC_EMPTY, 15, 15, 15, 1, 1));
    queue_req(sym_req(0, 1));
    queue_req(mk_req(FuncUnused, 15, 15, 15, 1, 1));
    // Transition added in the middle of a word
    queue_req(sym_req(0, 0));
    queue_req(mk_req(FUNC_ADD, 1, 2, 14, 0, 0));
    queue_req(sym_req(2, 1));
    // Fan-out to two states
    queue_req(mk_req(FUNC_ADD, 0, 0, 15, 0, 1));
    queue_req(sym_req(0, 1));
    queue_req(mk_req(FUNC_ADD, 14, 3, 0, 1, 1));
    queue_req(sym_req(0, 0));
    queue_req(sym_req(15, 0));
    queue_req(sym_req(0, 1));
  endtask

  // Mostly complete words; adds, empty words, ignored codes and cut words around them
  task automatic push_random(int unsigned count);
    int unsigned done;
    int unsigned roll;
    int unsigned len;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          queue_req(sym_req(SymbolW'($urandom_range(15)), i == len - 1));
        done += len;
      end else if (roll < 75) begin
        queue_req(rand_req(FUNC_ADD));
        done++;
      end else if (roll < 85) begin
        queue_req(rand_req(FUNC_EMPTY));
        done++;
      end else if (roll < 90) begin
        queue_req(rand_req(FuncUnused));
      end else begin
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          queue_req(sym_req(SymbolW'($urandom_range(15)), 1'b0));
        queue_req(rand_req($urandom_range(1) ? FUNC_ADD : FUNC_EMPTY));
        done += len + 1;
      end
    end
  endtask

  // Stimulus
  initial begin
    logic [StateW-1:0] ph_start;
    logic [MaskW-1:0]  ph_final;
    logic [StateW-1:0] ph_sink;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_START;
    cfg_data           = '0;
    req_if.valid       = 1'b0;
    req_if.func        = FUNC_ADD;
    req_if.from_state  = '0;
    req_if.symbol      = '0;
    req_if.next_state  = '0;
    req_if.to_sink     = 1'b0;
    req_if.last_symbol = 1'b0;
    rsp_if.ready       = 1'b0;
    req_accepted       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_cycles        = 0;
    errors             = 0;
    for (int i = 0; i < Depth; i++) trans_sets[i] = '0;
    active_states = '0;
    in_word       = 1'b0;
    start_reg     = StartReset;
    final_reg     = FinalReset;
    sink_reg      = SinkReset;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      ph_start = StateW'($urandom_range(15));
      ph_final = MaskW'($urandom_range(16'hffff));
      ph_sink  = StateW'($urandom_range(15));
      case (ph)
        0: begin ph_start = 0;  ph_final = 16'h8001; ph_sink = 15; end
        1: begin ph_start = 3;  ph_final = 16'h0ff0; ph_sink = 7;  end
        2: begin ph_start = 15; ph_final = 16'hffff; ph_sink = 0;  end
        3: begin ph_final = 16'h0000; ph_sink = 15; end
        4: ph_start = 0;
        default: ;
      endcase
      write_cfg(CFG_START, CfgDataW'(ph_start));
      write_cfg(CFG_FINAL, CfgDataW'(ph_final));
      write_cfg(CFG_SINK, CfgDataW'(ph_sink));
      send_idle_pct  = (ph == 1) ? 50 : (ph == 3 || ph == 5) ? 13 : 0;
      recv_stall_pct = (ph == 2) ? 50 : (ph == 3 || ph == 5) ? 13 : 0;
      if (ph == 0) push_directed();
      if (ph == 4) hold_cycles = 500;
      if (ph == 5) begin
        push_random(120);
        wait_drained();
        push_random(120);
      end else begin
        push_random(240);
      end
      // Close any open word before the next register change
      queue_req(rand_req(FUNC_EMPTY));
    end

    wait_drained();
    errors += verdicts_due.size();
    if (errors == 0) begin
      $display("nfa_word_acceptor test passed");
    end else begin
      $display("nfa_word_acceptor test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("nfa_word_acceptor test failed");
    $finish;
  end

endmodule
